FILE: design/stack_with_cursor_and_sum_top_macros.svh
// ----------------------------------------------------------------------------
// stack_with_cursor_and_sum_top_macros
// assertion shorthands used by the stack top
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_CURSOR_AND_SUM_TOP_MACROS_SVH
`define STACK_WITH_CURSOR_AND_SUM_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define SWCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// same-cycle implication
`define SWCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/swcs_pkg.sv
// ----------------------------------------------------------------------------
// swcs_pkg
// types and constants of the stack with cursor and sum
// ----------------------------------------------------------------------------
package swcs_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int CMD_W           = 4;
  localparam int VAL_W           = 32;
  localparam int DATA_W          = 40;
  localparam int STAT_W          = 3;
  localparam int MAG_W           = 38;
  localparam int DIV_CNT_W       = $clog2(MAG_W);
  localparam int AVG_SCALE       = 100;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 4'd0,
    CMD_POP    = 4'd1,
    CMD_SUM    = 4'd2,
    CMD_POW    = 4'd3,
    CMD_AVG    = 4'd4,
    CMD_PRINT  = 4'd5,
    CMD_SHOW   = 4'd6,
    CMD_LEFT   = 4'd7,
    CMD_RIGHT  = 4'd8,
    CMD_MODIFY = 4'd9
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_LEFT   = 3'd2,
    STAT_RIGHT  = 3'd3,
    STAT_FULL   = 3'd4,
    STAT_BEYOND = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_ABS,
    S_SCALE,
    S_ROUND,
    S_DIV,
    S_FIN,
    S_RD,
    S_USE,
    S_OUT
  } state_t;

endpackage

FILE: design/swcs_ram.sv
// ----------------------------------------------------------------------------
// swcs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/stack_with_cursor_and_sum_top.sv
// ----------------------------------------------------------------------------
// stack_with_cursor_and_sum_top
// lifo stack of 32-bit words in ram with edit cursor, sum, average and walks
// push, pop, left, right, modify give no result; errors return a status result
// sum reads one ram entry per cycle; average adds abs, scale, round, a 38-step divider
// print and pow give one result per entry (read, square for pow, output register)
// one transaction at a time; sync active-low reset clears count, cursor, control
// stack contents are undefined after reset, no clearing pass
// ----------------------------------------------------------------------------
`include "stack_with_cursor_and_sum_top_macros.svh"

module stack_with_cursor_and_sum_top
  import swcs_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_data,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            cursor_r, cursor_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [VAL_W-1:0]         acc_r, acc_nxt;
  logic                     neg_r, neg_nxt;
  logic [MAG_W-1:0]         quo_r, quo_nxt;
  logic [CW-1:0]            rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic signed [DATA_W-1:0] res_data_r, res_data_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic                     res_last_r, res_last_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;

  logic             accept, out_free, is_empty, is_full, cur_ok;
  logic             dec_err, dec_sum, dec_rd;
  status_t          dec_stat;
  logic             sum_issue, div_done, div_bit;
  logic [CW:0]      trial;
  logic [VAL_W-1:0] sq;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [VAL_W-1:0] wr_data, rd_data;

  swcs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(STACK_DEPTH));
  assign cur_ok    = (CW'(cursor_r) < count_r);
  assign sum_issue = (idx_r != count_r);
  assign div_done  = (div_cnt_r == DIV_CNT_W'(MAG_W - 1));
  assign trial     = {rem_r, quo_r[MAG_W-1]};
  assign div_bit   = (trial >= {1'b0, count_r});
  assign sq        = rd_data * rd_data;

  // command decode
  always_comb begin
    dec_err  = 1'b0;
    dec_sum  = 1'b0;
    dec_rd   = 1'b0;
    dec_stat = STAT_OK;
    case (in_cmd)
      CMD_PUSH: begin
        if (is_full) begin
          dec_err  = 1'b1;
          dec_stat = STAT_FULL;
        end
      end
      CMD_POP: begin
        if (is_empty) begin
          dec_err  = 1'b1;
          dec_stat = STAT_EMPTY;
        end
      end
      CMD_SUM: begin
        dec_sum = 1'b1;
      end
      CMD_AVG: begin
        if (is_empty) begin
          dec_err  = 1'b1;
          dec_stat = STAT_EMPTY;
        end else begin
          dec_sum = 1'b1;
        end
      end
      CMD_POW, CMD_PRINT: begin
        if (is_empty) begin
          dec_err  = 1'b1;
          dec_stat = STAT_EMPTY;
        end else begin
          dec_rd = 1'b1;
        end
      end
      CMD_SHOW, CMD_MODIFY: begin
        if (!cur_ok) begin
          dec_err  = 1'b1;
          dec_stat = status_t'(is_empty ? STAT_EMPTY : STAT_BEYOND);
        end else if (in_cmd == CMD_SHOW) begin
          dec_rd = 1'b1;
        end
      end
      CMD_LEFT: begin
        if (cursor_r == '0) begin
          dec_err  = 1'b1;
          dec_stat = STAT_LEFT;
        end
      end
      CMD_RIGHT: begin
        if (!((CW'(cursor_r) + CW'(1)) < count_r)) begin
          dec_err  = 1'b1;
          dec_stat = STAT_RIGHT;
        end
      end
      default: begin
        dec_err = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (dec_err) begin
            state_nxt = S_OUT;
          end else if (dec_sum) begin
            state_nxt = S_SUM;
          end else if (dec_rd) begin
            state_nxt = S_RD;
          end
        end
      end
      S_SUM: begin
        if (!sum_issue && !pend_r) begin
          state_nxt = (cmd_r == CMD_SUM) ? S_OUT : S_ABS;
        end
      end
      S_ABS:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: state_nxt = S_OUT;
      S_RD:  state_nxt = S_USE;
      S_USE: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = res_last_r ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = in_value;
    rd_en          = 1'b0;
    rd_addr        = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_cmd);
          acc_nxt = '0;
          idx_nxt = '0;
          if (dec_err) begin
            res_data_nxt   = '0;
            res_status_nxt = dec_stat;
            res_last_nxt   = 1'b1;
          end else begin
            case (in_cmd)
              CMD_PUSH: begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
              CMD_POP:    count_nxt = count_r - CW'(1);
              CMD_SHOW:   idx_nxt = CW'(cursor_r);
              CMD_LEFT:   cursor_nxt = cursor_r - AW'(1);
              CMD_RIGHT:  cursor_nxt = cursor_r + AW'(1);
              CMD_MODIFY: begin
                wr_en   = 1'b1;
                wr_addr = cursor_r;
              end
              default: begin
                wr_en = 1'b0;
              end
            endcase
          end
        end
      end
      S_SUM: begin
        rd_en    = sum_issue;
        pend_nxt = sum_issue;
        if (sum_issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pend_r) begin
          acc_nxt = acc_r + rd_data;
        end
        res_data_nxt   = {{(DATA_W-VAL_W){acc_r[VAL_W-1]}}, acc_r};
        res_status_nxt = STAT_OK;
        res_last_nxt   = 1'b1;
      end
      S_ABS: begin
        neg_nxt = acc_r[VAL_W-1];
        acc_nxt = acc_r[VAL_W-1] ? (VAL_W'(0) - acc_r) : acc_r;
      end
      S_SCALE: begin
        quo_nxt = MAG_W'(acc_r) * MAG_W'(AVG_SCALE);
      end
      S_ROUND: begin
        quo_nxt     = quo_r + MAG_W'(count_r >> 1);
        rem_nxt     = '0;
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        rem_nxt     = div_bit ? CW'(trial - {1'b0, count_r}) : trial[CW-1:0];
        quo_nxt     = {quo_r[MAG_W-2:0], div_bit};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      end
      S_FIN: begin
        res_data_nxt   = neg_r ? (DATA_W'(0) - DATA_W'(quo_r)) : DATA_W'(quo_r);
        res_status_nxt = STAT_OK;
        res_last_nxt   = 1'b1;
      end
      S_RD: begin
        rd_en = 1'b1;
      end
      S_USE: begin
        if (cmd_r == CMD_POW) begin
          res_data_nxt = {{(DATA_W-VAL_W){sq[VAL_W-1]}}, sq};
        end else begin
          res_data_nxt = {{(DATA_W-VAL_W){rd_data[VAL_W-1]}}, rd_data};
        end
        res_status_nxt = STAT_OK;
        res_last_nxt   = (cmd_r == CMD_SHOW) || ((idx_r + CW'(1)) == count_r);
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          idx_nxt        = idx_r + CW'(1);
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  `SWCS_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(STACK_DEPTH), "entry count beyond depth")
  `SWCS_ASSERT_SAME(a_write_idle, wr_en, state_r == S_IDLE, "stack write outside idle")
  `SWCS_ASSERT_SAME(a_walk_range, state_r == S_RD, idx_r < count_r, "walk index beyond top")
  `SWCS_ASSERT_NEXT(a_out_load, state_r == S_OUT && out_free, out_valid_r && out_last_r == $past(res_last_r), "result not loaded")

endmodule
